/* src/dced_pkg.sv */
// Shared types, constants and helper functions for the dumbbell cell edge distance block.
// No dependencies; every other file refers to this package by scoped names.
package dced_pkg;

  // Angle format: a full turn is 2^ANGLE_BITS.
  localparam int ANGLE_BITS = 16;

  // Q30 one and the quarter-wave sine polynomial coefficients.
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] POLY_C9 = 32'd172272;
  localparam logic [31:0] POLY_COEF [4] = '{32'd5026995, 32'd85569306,
                                            32'd693598668, 32'd1686629713};

  // Square root of the squared distance.
  localparam int SQ_W = 53;
  localparam int RT_W = 54;
  localparam int SQRT_STEPS = 27;
  localparam int STEPS_PER_STAGE = 3;
  localparam int SQRT_STAGES = SQRT_STEPS / STEPS_PER_STAGE;

  // Input register, poly start, four poly steps, quarter value, offset, centers,
  // differences, squares, sums, minimum, root stages, output register.
  localparam int PIPE_DEPTH = 14 + SQRT_STAGES;

  localparam logic signed [28:0] OUT_MAX = 29'sd33554431;
  localparam logic signed [28:0] OUT_MIN = -29'sd33554432;

  typedef struct packed {
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic [15:0]        first_axis_length;
    logic [15:0]        first_radius;
    logic [15:0]        first_angle;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
    logic [15:0]        second_axis_length;
    logic [15:0]        second_radius;
    logic [15:0]        second_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [25:0] edge_distance;
  } out_item_t;

  // Per-item geometry carried alongside the trig pipeline.
  typedef struct packed {
    logic [1:0][23:0] cx;
    logic [1:0][23:0] cy;
    logic [1:0][16:0] span;
    logic [1:0][1:0]  quad;
    logic [16:0]      rsum;
  } geo_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [RT_W-1:0] r;
  } sqrt_st_t;

  // One step of the digit-by-digit integer square root.
  function automatic sqrt_st_t sqrt_step(logic [SQ_W-1:0] v, logic [RT_W-1:0] r,
                                         logic [RT_W-1:0] b);
    sqrt_st_t o;
    logic [RT_W-1:0] t;
    t = r + b;
    if (RT_W'(v) >= t) begin
      o.v = SQ_W'(RT_W'(v) - t);
      o.r = (r >> 1) + b;
    end else begin
      o.v = v;
      o.r = r >> 1;
    end
    return o;
  endfunction

endpackage

/* src/dced_in_if.sv */
// Input channel: valid/ready handshake carrying one pair of cells per beat.
// Depends on dced_pkg for the payload type.
interface dced_in_if;
  logic               valid;
  logic               ready;
  dced_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/dced_out_if.sv */
// Output channel: valid/ready handshake carrying one edge distance per beat.
// Depends on dced_pkg for the payload type.
interface dced_out_if;
  logic                valid;
  logic                ready;
  dced_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/dumbbell_cell_edge_distance.sv */
// Dumbbell cell edge distance pipeline, top level.
// Depends on dced_pkg, dced_in_if and dced_out_if.
//
// Usage: in_ch carries one beat per cell pair (center, axis length, radius and
// angle of each cell); out_ch returns one beat with the signed edge-to-edge
// distance (8 fraction bits, saturated to 26 bits) for every input beat, in order.
// Throughput is one pair per cycle unless out_ch stalls. The pipe has 23 register
// stages, which a beat passes in this order: one input register, six stages for
// the sine and cosine polynomials (one multiplier level each), offset, centers,
// differences, squares, sums, minimum, nine square root stages of three digit
// steps each and the output register. Since the rounded root is monotonic, only
// the smallest of the four squared distances goes through the root.
// The pipeline advances as a whole: when out_ch holds a beat that is not taken,
// every stage holds and in_ch.ready is low; otherwise a beat enters each cycle.
// Synchronous reset clears all valid bits; payload registers are not reset.
module dumbbell_cell_edge_distance (
  input logic      clk,
  input logic      rst,
  dced_in_if.sink  in_ch,
  dced_out_if.source out_ch
);

  localparam int LAST = dced_pkg::PIPE_DEPTH - 1;

  logic [LAST:0] vld;
  logic          en;

  // Global stall: the pipe moves when the output register is free or being taken.
  assign en = !vld[LAST] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_ch.valid};
    end
  end

  // Input stage: unpack both cells and form the quarter-wave arguments.
  logic [3:0][30:0] arg_in;
  dced_pkg::geo_t   geo_in;

  always_comb begin
    arg_in[0] = 31'(in_ch.data.first_angle[dced_pkg::ANGLE_BITS-3:0])
                << (32 - dced_pkg::ANGLE_BITS);
    arg_in[1] = dced_pkg::Q30_ONE - arg_in[0];
    arg_in[2] = 31'(in_ch.data.second_angle[dced_pkg::ANGLE_BITS-3:0])
                << (32 - dced_pkg::ANGLE_BITS);
    arg_in[3] = dced_pkg::Q30_ONE - arg_in[2];
    geo_in.cx[0] = in_ch.data.first_x;
    geo_in.cy[0] = in_ch.data.first_y;
    geo_in.cx[1] = in_ch.data.second_x;
    geo_in.cy[1] = in_ch.data.second_y;
    geo_in.span[0] = 17'(in_ch.data.first_axis_length) - 17'(in_ch.data.first_radius);
    geo_in.span[1] = 17'(in_ch.data.second_axis_length) - 17'(in_ch.data.second_radius);
    geo_in.quad[0] = in_ch.data.first_angle[dced_pkg::ANGLE_BITS-1 -: 2];
    geo_in.quad[1] = in_ch.data.second_angle[dced_pkg::ANGLE_BITS-1 -: 2];
    geo_in.rsum = 17'(in_ch.data.first_radius) + 17'(in_ch.data.second_radius);
  end

  logic [3:0][30:0] a_arg;
  dced_pkg::geo_t   a_geo;

  always_ff @(posedge clk) begin
    if (en) begin
      a_arg <= arg_in;
      a_geo <= geo_in;
    end
  end

  // Polynomial stages: s = x*x, then four Horner steps p = c - s*p.
  logic [30:0]    ps_arg [0:4][4];
  logic [30:0]    ps_s   [0:4][4];
  logic [31:0]    ps_p   [0:4][4];
  dced_pkg::geo_t ps_geo [0:4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ps_arg[0][k] <= a_arg[k];
        ps_s[0][k]   <= 31'((62'(a_arg[k]) * 62'(a_arg[k])) >> 30);
        ps_p[0][k]   <= dced_pkg::POLY_C9;
      end
      ps_geo[0] <= a_geo;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_horner
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          ps_arg[j+1][k] <= ps_arg[j][k];
          ps_s[j+1][k]   <= ps_s[j][k];
          ps_p[j+1][k]   <= dced_pkg::POLY_COEF[j]
                            - 32'((63'(ps_s[j][k]) * 63'(ps_p[j][k])) >> 30);
        end
        ps_geo[j+1] <= ps_geo[j];
      end
    end
  end

  // Quarter-wave value x*p, clamped to one.
  logic [30:0]    q_r [4];
  dced_pkg::geo_t q_geo;
  logic [32:0]    q_t [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_t[k] = 33'((63'(ps_arg[4][k]) * 63'(ps_p[4][k])) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q_r[k] <= (q_t[k] > 33'(dced_pkg::Q30_ONE)) ? dced_pkg::Q30_ONE : q_t[k][30:0];
      end
      q_geo <= ps_geo[4];
    end
  end

  // Quadrant fold and offset = round(span * trig / 2^31), ties up.
  logic signed [31:0] sin_v [2];
  logic signed [31:0] cos_v [2];
  logic signed [31:0] tc    [2];
  logic signed [31:0] ts    [2];
  logic signed [48:0] pcx   [2];
  logic signed [48:0] pcy   [2];
  logic signed [48:0] rcx   [2];
  logic signed [48:0] rcy   [2];
  logic signed [16:0] spn   [2];
  logic signed [16:0] o_ox  [2];
  logic signed [16:0] o_oy  [2];
  dced_pkg::geo_t     o_geo;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sin_v[c] = $signed({1'b0, q_r[2*c]});
      cos_v[c] = $signed({1'b0, q_r[2*c+1]});
      case (q_geo.quad[c])
        2'd0: begin
          tc[c] = cos_v[c];
          ts[c] = sin_v[c];
        end
        2'd1: begin
          tc[c] = -sin_v[c];
          ts[c] = cos_v[c];
        end
        2'd2: begin
          tc[c] = -cos_v[c];
          ts[c] = -sin_v[c];
        end
        default: begin
          tc[c] = sin_v[c];
          ts[c] = -cos_v[c];
        end
      endcase
      spn[c] = $signed(q_geo.span[c]);
      pcx[c] = spn[c] * tc[c];
      pcy[c] = spn[c] * ts[c];
      rcx[c] = pcx[c] + (49'sd1 <<< 30);
      rcy[c] = pcy[c] + (49'sd1 <<< 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        o_ox[c] <= rcx[c][47:31];
        o_oy[c] <= rcy[c][47:31];
      end
      o_geo <= q_geo;
    end
  end

  // Sphere centers: index [cell][end], end 0 at +offset.
  logic signed [24:0] c_px [2][2];
  logic signed [24:0] c_py [2][2];
  logic [16:0]        c_rs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        c_px[c][0] <= 25'($signed(o_geo.cx[c])) + 25'(o_ox[c]);
        c_py[c][0] <= 25'($signed(o_geo.cy[c])) + 25'(o_oy[c]);
        c_px[c][1] <= 25'($signed(o_geo.cx[c])) - 25'(o_ox[c]);
        c_py[c][1] <= 25'($signed(o_geo.cy[c])) - 25'(o_oy[c]);
      end
      c_rs <= o_geo.rsum;
    end
  end

  // Coordinate differences for the four center pairs.
  logic signed [25:0] d_dx [4];
  logic signed [25:0] d_dy [4];
  logic [16:0]        d_rs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          d_dx[2*i+j] <= 26'(c_px[0][i]) - 26'(c_px[1][j]);
          d_dy[2*i+j] <= 26'(c_py[0][i]) - 26'(c_py[1][j]);
        end
      end
      d_rs <= c_rs;
    end
  end

  // Squares.
  logic signed [51:0] mx [4];
  logic signed [51:0] my [4];
  logic [50:0]        s_x [4];
  logic [50:0]        s_y [4];
  logic [16:0]        s_rs;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      mx[p] = d_dx[p] * d_dx[p];
      my[p] = d_dy[p] * d_dy[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        s_x[p] <= mx[p][50:0];
        s_y[p] <= my[p][50:0];
      end
      s_rs <= d_rs;
    end
  end

  // Squared distances.
  logic [dced_pkg::SQ_W-1:0] u_sq [4];
  logic [16:0]               u_rs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        u_sq[p] <= dced_pkg::SQ_W'(s_x[p]) + dced_pkg::SQ_W'(s_y[p]);
      end
      u_rs <= s_rs;
    end
  end

  // Smallest squared distance, two-level compare tree.
  logic [dced_pkg::SQ_W-1:0] mn0;
  logic [dced_pkg::SQ_W-1:0] mn1;
  logic [dced_pkg::SQ_W-1:0] mn;

  always_comb begin
    mn0 = (u_sq[1] < u_sq[0]) ? u_sq[1] : u_sq[0];
    mn1 = (u_sq[3] < u_sq[2]) ? u_sq[3] : u_sq[2];
    mn  = (mn1 < mn0) ? mn1 : mn0;
  end

  // Square root stages; index 0 holds the minimum with a zero root.
  logic [dced_pkg::SQ_W-1:0] rt_v  [0:dced_pkg::SQRT_STAGES];
  logic [dced_pkg::RT_W-1:0] rt_r  [0:dced_pkg::SQRT_STAGES];
  logic [16:0]               rt_rs [0:dced_pkg::SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_v[0]  <= mn;
      rt_r[0]  <= '0;
      rt_rs[0] <= u_rs;
    end
  end

  for (genvar g = 0; g < dced_pkg::SQRT_STAGES; g++) begin : g_sqrt
    dced_pkg::sqrt_st_t st [0:dced_pkg::STEPS_PER_STAGE];

    always_comb begin
      st[0].v = rt_v[g];
      st[0].r = rt_r[g];
      for (int t = 0; t < dced_pkg::STEPS_PER_STAGE; t++) begin
        st[t+1] = dced_pkg::sqrt_step(st[t].v, st[t].r,
          dced_pkg::RT_W'(1) << (2 * (dced_pkg::SQRT_STEPS - 1
                                      - g * dced_pkg::STEPS_PER_STAGE - t)));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_v[g+1]  <= st[dced_pkg::STEPS_PER_STAGE].v;
        rt_r[g+1]  <= st[dced_pkg::STEPS_PER_STAGE].r;
        rt_rs[g+1] <= rt_rs[g];
      end
    end
  end

  // Round the root, subtract both radii and saturate.
  logic [dced_pkg::RT_W-1:0] best;
  logic signed [28:0]        res;
  logic signed [28:0]        res_sat;

  always_comb begin
    best = rt_r[dced_pkg::SQRT_STAGES]
           + dced_pkg::RT_W'(dced_pkg::RT_W'(rt_v[dced_pkg::SQRT_STAGES])
                             > rt_r[dced_pkg::SQRT_STAGES]);
    res = $signed({1'b0, best[27:0]}) - $signed({12'b0, rt_rs[dced_pkg::SQRT_STAGES]});
    if (res > dced_pkg::OUT_MAX) begin
      res_sat = dced_pkg::OUT_MAX;
    end else if (res < dced_pkg::OUT_MIN) begin
      res_sat = dced_pkg::OUT_MIN;
    end else begin
      res_sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.data.edge_distance <= res_sat[25:0];
    end
  end

  // A held output beat blocks new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // During a stall no stage gains or loses a beat.
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid after reset");

  // The root remainder never exceeds twice the root.
  a_root_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[LAST-1] |-> (dced_pkg::RT_W'(rt_v[dced_pkg::SQRT_STAGES])
                     <= (rt_r[dced_pkg::SQRT_STAGES] << 1)))
    else $error("square root remainder out of bound");

endmodule
